// ===== rtl/core/bra_pkg.sv =====
// ----------------------------------------------------------------------------
// bra_pkg: shared types and constants of the bitmap run page allocator
// Request and status codes, register indexes and controller/datapath buses.
// ----------------------------------------------------------------------------
package bra_pkg;

	localparam int MAX_PAGES_DEF     = 4096;
	localparam int MAP_WORD_BITS_DEF = 64;
	localparam int CHUNK_BITS        = 8;

	localparam int REQ_W     = 2;
	localparam int START_W   = 12;
	localparam int LEN_W     = 14;
	localparam int CFG_W     = 13;
	localparam int CFG_IDX_W = 8;
	localparam int STATUS_W  = 2;

	localparam logic [REQ_W-1:0] REQ_ALLOC  = 2'd0;
	localparam logic [REQ_W-1:0] REQ_FREE   = 2'd1;
	localparam logic [REQ_W-1:0] REQ_FORMAT = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
	localparam logic [STATUS_W-1:0] ST_NEG   = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_TOTAL    = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RESERVED = 8'd1;

	localparam logic [CFG_W-1:0] TOTAL_RST    = 13'd4096;
	localparam logic [CFG_W-1:0] RESERVED_RST = 13'd2;

	typedef struct packed {
		logic                load;
		logic                rd;
		logic                scan;
		logic                next_word;
		logic                mark_init;
		logic                mark_wr;
		logic                fmt_clear;
		logic                res_we;
		logic [STATUS_W-1:0] res_status;
	} cmd_t;

	typedef struct packed {
		logic [REQ_W-1:0] req;
		logic             neg;
		logic             len_zero;
		logic             free_bad;
		logic             resv_bad;
		logic             scan_found;
		logic             scan_over;
		logic             last_chunk;
		logic             m_done;
		logic             m_skip;
		logic             last_word;
	} stat_t;

endpackage

// ===== rtl/core/bra_req_if.sv =====
// ----------------------------------------------------------------------------
// bra_req_if: request channel
// Carries one allocate, free or format request per beat.
// ----------------------------------------------------------------------------
interface bra_req_if;
	import bra_pkg::*;
	logic                    valid;
	logic                    ready;
	logic [REQ_W-1:0]        req_type;
	logic [START_W-1:0]      first_page;
	logic signed [LEN_W-1:0] run_length;

	modport source (output valid, output req_type, output first_page, output run_length,
		input ready);
	modport sink (input valid, input req_type, input first_page, input run_length,
		output ready);
endinterface

// ===== rtl/core/bra_res_if.sv =====
// ----------------------------------------------------------------------------
// bra_res_if: result channel
// Carries one status and allocated start page per beat.
// ----------------------------------------------------------------------------
interface bra_res_if;
	import bra_pkg::*;
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [START_W-1:0]  alloc_start;

	modport source (output valid, output status, output alloc_start, input ready);
	modport sink (input valid, input status, input alloc_start, output ready);
endinterface

// ===== rtl/core/bra_cfg_if.sv =====
// ----------------------------------------------------------------------------
// bra_cfg_if: configuration write channel
// Carries one register index and write data per beat.
// ----------------------------------------------------------------------------
interface bra_cfg_if;
	import bra_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_W-1:0]     data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/bra_datapath.sv =====
// ----------------------------------------------------------------------------
// bra_datapath: occupancy map, scan and marking datapath
// Holds the map memory, the first-fit run tracker and the word masks.
// ----------------------------------------------------------------------------
module bra_datapath #(
	parameter int MAX_PAGES     = bra_pkg::MAX_PAGES_DEF,
	parameter int MAP_WORD_BITS = bra_pkg::MAP_WORD_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  bra_pkg::cmd_t                    cmd,
	output bra_pkg::stat_t                   stat,
	input  logic [bra_pkg::REQ_W-1:0]        req_type,
	input  logic [bra_pkg::START_W-1:0]      first_page,
	input  logic signed [bra_pkg::LEN_W-1:0] run_length,
	input  logic [bra_pkg::CFG_W-1:0]        total_pages,
	input  logic [bra_pkg::CFG_W-1:0]        reserved_pages,
	output logic [bra_pkg::STATUS_W-1:0]     status,
	output logic [bra_pkg::START_W-1:0]      alloc_start
);
	import bra_pkg::*;

	localparam int MW   = (MAX_PAGES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
	localparam int WAW  = (MW > 1) ? $clog2(MW) : 1;
	localparam int NCH  = (MAP_WORD_BITS + CHUNK_BITS - 1) / CHUNK_BITS;
	localparam int CHW  = (NCH > 1) ? $clog2(NCH) : 1;
	localparam int WPAD = NCH * CHUNK_BITS;
	localparam int AW   = $clog2(MW * MAP_WORD_BITS + 2 * MAP_WORD_BITS + 16384);

	logic [MAP_WORD_BITS-1:0] mem [MW];
	logic [MW-1:0]            vld_q;
	logic [MAP_WORD_BITS-1:0] rdata_q;
	logic                     rvld_q;

	logic [REQ_W-1:0] req_q;
	logic             neg_q;
	logic             set_q;
	logic             found_q;
	logic [AW-1:0]    len_q, start_q, n_q, resv_q;
	logic [AW-1:0]    base_q, rl_q, rs_q, lo_q, hi_q;
	logic [WAW-1:0]   wi_q;
	logic [CHW-1:0]   ci_q;

	logic [MAP_WORD_BITS-1:0] word, mask, wdata;
	logic [WPAD-1:0]          wpad;
	logic [CHUNK_BITS-1:0]    chunk;
	logic [AW-1:0]            cb, end_pg, rl_c, rs_c, pg, tot, n_c;
	logic                     f_c, last_chunk;

	assign word       = rvld_q ? rdata_q : '0;
	assign wpad       = WPAD'(word);
	assign chunk      = wpad[ci_q * CHUNK_BITS +: CHUNK_BITS];
	assign cb         = base_q + AW'(ci_q) * AW'(CHUNK_BITS);
	assign last_chunk = (ci_q == CHW'(NCH - 1));
	assign end_pg     = last_chunk ? base_q + AW'(MAP_WORD_BITS) : cb + AW'(CHUNK_BITS);

	// Walk one chunk of pages, restarting the run at every used page.
	always_comb begin
		rl_c = rl_q;
		rs_c = rs_q;
		f_c  = 1'b0;
		pg   = cb;
		for (int k = 0; k < CHUNK_BITS; k++) begin
			pg = cb + AW'(k);
			if (!f_c && pg < n_q && (int'(ci_q) * CHUNK_BITS + k) < MAP_WORD_BITS) begin
				if (chunk[k]) begin
					rs_c = pg + AW'(1);
					rl_c = '0;
				end else begin
					rl_c = rl_c + AW'(1);
				end
				if (rl_c >= len_q) begin
					f_c = 1'b1;
				end
			end
		end
	end

	always_comb begin
		for (int b = 0; b < MAP_WORD_BITS; b++) begin
			mask[b] = (base_q + AW'(b) >= lo_q) && (base_q + AW'(b) < hi_q);
		end
		wdata = set_q ? (word | mask) : (word & ~mask);
	end

	assign tot = AW'(total_pages);
	assign n_c = (tot < AW'(2)) ? AW'(2) : ((tot > AW'(MAX_PAGES)) ? AW'(MAX_PAGES) : tot);

	always_comb begin
		stat.req        = req_q;
		stat.neg        = neg_q;
		stat.len_zero   = (len_q == '0);
		stat.free_bad   = (start_q + len_q > n_q);
		stat.resv_bad   = (resv_q > n_q);
		stat.scan_found = f_c;
		stat.scan_over  = (end_pg >= n_q);
		stat.last_chunk = last_chunk;
		stat.m_done     = (base_q >= hi_q);
		stat.m_skip     = (base_q + AW'(MAP_WORD_BITS) <= lo_q);
		stat.last_word  = (wi_q == WAW'(MW - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
			wi_q    <= '0;
			ci_q    <= '0;
			base_q  <= '0;
			rl_q    <= '0;
			rs_q    <= '0;
		end else begin
			if (cmd.load) begin
				found_q <= 1'b0;
				wi_q    <= '0;
				ci_q    <= '0;
				base_q  <= '0;
				rl_q    <= '0;
				rs_q    <= '0;
			end
			if (cmd.scan) begin
				rl_q    <= rl_c;
				rs_q    <= rs_c;
				found_q <= f_c;
				ci_q    <= ci_q + CHW'(1);
			end
			if (cmd.mark_init) begin
				wi_q   <= '0;
				base_q <= '0;
			end
			if (cmd.next_word) begin
				wi_q   <= wi_q + WAW'(1);
				base_q <= base_q + AW'(MAP_WORD_BITS);
				ci_q   <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q   <= req_type;
			start_q <= AW'(first_page);
			neg_q   <= run_length[LEN_W-1];
			len_q   <= AW'(run_length[LEN_W-2:0]);
			n_q     <= n_c;
			resv_q  <= AW'(reserved_pages);
		end
		if (cmd.mark_init) begin
			case (req_q)
				REQ_ALLOC: begin
					lo_q  <= rs_q;
					hi_q  <= rs_q + len_q;
					set_q <= 1'b1;
				end
				REQ_FREE: begin
					lo_q  <= start_q;
					hi_q  <= start_q + len_q;
					set_q <= 1'b0;
				end
				default: begin
					lo_q  <= '0;
					hi_q  <= resv_q;
					set_q <= 1'b1;
				end
			endcase
		end
		if (cmd.res_we) begin
			status      <= cmd.res_status;
			alloc_start <= (req_q == REQ_ALLOC && found_q) ? rs_q[START_W-1:0] : '0;
		end
	end

	// Map memory: one word written or read per cycle, read data registered.
	always_ff @(posedge clk) begin
		if (cmd.mark_wr) begin
			mem[wi_q] <= wdata;
		end
		if (cmd.rd) begin
			rdata_q <= mem[wi_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (cmd.fmt_clear) begin
				vld_q <= '0;
			end else if (cmd.mark_wr) begin
				vld_q[wi_q] <= 1'b1;
			end
			if (cmd.rd) begin
				rvld_q <= vld_q[wi_q];
			end
		end
	end

endmodule

// ===== rtl/core/bra_ctrl.sv =====
// ----------------------------------------------------------------------------
// bra_ctrl: request sequencer
// Decodes a request, steps the scan and marking passes, hands off results.
// ----------------------------------------------------------------------------
module bra_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  bra_pkg::stat_t stat,
	output bra_pkg::cmd_t  cmd
);
	import bra_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_DEC   = 3'd1;
	localparam logic [2:0] S_RD    = 3'd2;
	localparam logic [2:0] S_SCAN  = 3'd3;
	localparam logic [2:0] S_MINIT = 3'd4;
	localparam logic [2:0] S_MSTEP = 3'd5;
	localparam logic [2:0] S_MWR   = 3'd6;
	localparam logic [2:0] S_FIN   = 3'd7;

	logic [2:0]          state_q, nxt;
	logic [STATUS_W-1:0] st_q, st_nxt;
	logic                out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd            = '0;
		cmd.res_status = st_q;
		nxt            = state_q;
		st_nxt         = st_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					nxt      = S_DEC;
				end
			end
			S_DEC: begin
				st_nxt = ST_OK;
				nxt    = S_FIN;
				case (stat.req)
					REQ_ALLOC: begin
						if (stat.neg) begin
							st_nxt = ST_NEG;
						end else if (!stat.len_zero) begin
							nxt = S_RD;
						end
					end
					REQ_FREE: begin
						if (stat.neg) begin
							st_nxt = ST_NEG;
						end else if (stat.free_bad) begin
							st_nxt = ST_RANGE;
						end else if (!stat.len_zero) begin
							nxt = S_MINIT;
						end
					end
					REQ_FORMAT: begin
						cmd.fmt_clear = 1'b1;
						if (stat.resv_bad) begin
							st_nxt = ST_RANGE;
						end else begin
							nxt = S_MINIT;
						end
					end
					default: begin
						st_nxt = ST_OK;
					end
				endcase
			end
			S_RD: begin
				cmd.rd = 1'b1;
				nxt    = S_SCAN;
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.scan_found) begin
					nxt = S_MINIT;
				end else if (stat.scan_over) begin
					st_nxt = ST_FULL;
					nxt    = S_FIN;
				end else if (stat.last_chunk) begin
					cmd.next_word = 1'b1;
					nxt           = S_RD;
				end
			end
			S_MINIT: begin
				cmd.mark_init = 1'b1;
				nxt           = S_MSTEP;
			end
			S_MSTEP: begin
				if (stat.m_done) begin
					nxt = S_FIN;
				end else if (stat.m_skip) begin
					if (stat.last_word) begin
						nxt = S_FIN;
					end else begin
						cmd.next_word = 1'b1;
					end
				end else begin
					cmd.rd = 1'b1;
					nxt    = S_MWR;
				end
			end
			S_MWR: begin
				cmd.mark_wr = 1'b1;
				if (stat.last_word) begin
					nxt = S_FIN;
				end else begin
					cmd.next_word = 1'b1;
					nxt           = S_MSTEP;
				end
			end
			S_FIN: begin
				if (!out_valid_q || out_ready) begin
					cmd.res_we = 1'b1;
					nxt        = S_IDLE;
				end
			end
			default: begin
				nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			st_q        <= ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= nxt;
			st_q    <= st_nxt;
			if (cmd.res_we) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/core/bitmap_run_page_allocator.sv =====
// ----------------------------------------------------------------------------
// bitmap_run_page_allocator: first-fit contiguous page allocator
// One bit per page occupancy map serving allocate, free and format requests.
// ----------------------------------------------------------------------------
// Usage:
//   req  : request beats (req_type, first_page, run_length). Taken one at a
//          time; ready is high only while the sequencer is idle.
//   res  : exactly one result beat per request (status, alloc_start).
//   cfg  : register writes, always ready. Index 0 total_pages, index 1
//          reserved_pages; other indexes are dropped. Write only while idle.
// Sequence:
//   A request is loaded, decoded and then handed off as a result. An allocate
//   scans the map word by word (one registered map read, then one 8-page
//   step per cycle), then marks the run, reading and then writing each
//   touched word and passing over each skipped word. A free walks the
//   words up to the run end the same way; a format rewrites the reserved
//   words. Map memory has a single port.
// Reset:
//   Per-word valid bits clear at once, so the whole map reads free with no
//   clearing pass; registers return to 4096 total and 2 reserved pages.
// Stall:
//   The result register holds its beat while res.ready is low; the next
//   request is accepted meanwhile and its result waits for the slot.
// ----------------------------------------------------------------------------
module bitmap_run_page_allocator #(
	parameter int MAX_PAGES     = bra_pkg::MAX_PAGES_DEF,
	parameter int MAP_WORD_BITS = bra_pkg::MAP_WORD_BITS_DEF
) (
	input logic  clk,
	input logic  arst_n,
	bra_req_if.sink   req,
	bra_res_if.source res,
	bra_cfg_if.sink   cfg
);
	import bra_pkg::*;

	cmd_t             cmd;
	stat_t            stat;
	logic [CFG_W-1:0] total_q, resv_q;

	// Configuration registers: always accept, drop unknown indexes.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= TOTAL_RST;
			resv_q  <= RESERVED_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_TOTAL:    total_q <= cfg.data;
				CFG_RESERVED: resv_q  <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	bra_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (res.valid),
		.out_ready (res.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	bra_datapath #(
		.MAX_PAGES     (MAX_PAGES),
		.MAP_WORD_BITS (MAP_WORD_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.req_type       (req.req_type),
		.first_page     (req.first_page),
		.run_length     (req.run_length),
		.total_pages    (total_q),
		.reserved_pages (resv_q),
		.status         (res.status),
		.alloc_start    (res.alloc_start)
	);

endmodule

// ===== rtl/core/bra_checker.sv =====
// ----------------------------------------------------------------------------
// bra_checker: port-level checks of the allocator
// Result channel holds under stall and failed results carry no start page.
// ----------------------------------------------------------------------------
module bra_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            res_valid,
	input logic                            res_ready,
	input logic [bra_pkg::STATUS_W-1:0]    res_status,
	input logic [bra_pkg::START_W-1:0]     res_alloc_start
);
	import bra_pkg::*;

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result beat dropped under stall");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(res_status) && $stable(res_alloc_start))
		else $error("result beat changed under stall");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_status != ST_OK |-> res_alloc_start == '0)
		else $error("failed result carries a start page");

	a_reset_idle: assert property (@(posedge clk)
		!arst_n |-> !res_valid)
		else $error("result valid during reset");

endmodule

bind bitmap_run_page_allocator bra_checker u_bra_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.res_valid       (res.valid),
	.res_ready       (res.ready),
	.res_status      (res.status),
	.res_alloc_start (res.alloc_start)
);

// ===== sim/bra_tb_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bra_tb_checker: result predictor and comparator for the page allocator
// Watches request, config and result beats, keeps its own occupancy map and
// compares every result beat with the oldest predicted one.
// ----------------------------------------------------------------------------
module bra_tb_checker (
	input logic clk,
	input logic arst_n,
	bra_req_if.sink   req_mon,
	bra_res_if.sink   res_mon,
	bra_cfg_if.sink   cfg_mon,
	output int        fail_count,
	output int        pending_results
);
	import bra_pkg::*;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [START_W-1:0]  alloc_start;
	} alloc_result_t;

	localparam int NPAGES = MAX_PAGES_DEF;

	logic [NPAGES-1:0] page_map;
	logic [CFG_W-1:0]  total_reg;
	logic [CFG_W-1:0]  resv_reg;
	alloc_result_t     result_queue[$];

	assign pending_results = result_queue.size();

	function automatic alloc_result_t predict_request(logic [REQ_W-1:0] kind,
			logic [START_W-1:0] first, logic signed [LEN_W-1:0] len_s);
		alloc_result_t r;
		int n, len, run_start, run_len;
		r = '0;
		n = total_reg;
		if (n < 2) n = 2;
		if (n > NPAGES) n = NPAGES;
		len = len_s;
		if (kind == REQ_ALLOC) begin
			if (len < 0) begin
				r.status = ST_NEG;
			end else if (len != 0) begin
				run_start = 0;
				run_len = 0;
				for (int p = 0; p < n && run_len < len; p++) begin
					if (page_map[p]) begin
						run_start = p + 1;
						run_len = 0;
					end else begin
						run_len++;
					end
				end
				if (run_len >= len) begin
					for (int i = 0; i < len; i++) page_map[run_start + i] = 1'b1;
					r.alloc_start = run_start[START_W-1:0];
				end else begin
					r.status = ST_FULL;
				end
			end
		end else if (kind == REQ_FREE) begin
			if (len < 0) begin
				r.status = ST_NEG;
			end else if (int'(first) + len > n) begin
				r.status = ST_RANGE;
			end else begin
				for (int i = 0; i < len; i++) page_map[int'(first) + i] = 1'b0;
			end
		end else if (kind == REQ_FORMAT) begin
			page_map = '0;
			if (int'(resv_reg) > n) r.status = ST_RANGE;
			else for (int i = 0; i < int'(resv_reg); i++) page_map[i] = 1'b1;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		alloc_result_t want;
		if (!arst_n) begin
			page_map   = '0;
			total_reg  = TOTAL_RST;
			resv_reg   = RESERVED_RST;
			fail_count = 0;
			result_queue.delete();
		end else begin
			if (cfg_mon.valid && cfg_mon.ready) begin
				if (cfg_mon.index == CFG_TOTAL) total_reg = cfg_mon.data;
				else if (cfg_mon.index == CFG_RESERVED) resv_reg = cfg_mon.data;
			end
			if (res_mon.valid && res_mon.ready) begin
				if (result_queue.size() == 0) begin
					$display("%0t: unexpected result status=%0d start=%0d", $time,
						res_mon.status, res_mon.alloc_start);
					fail_count++;
				end else begin
					want = result_queue.pop_front();
					if (want.status !== res_mon.status) begin
						$display("%0t: status expected %0d actual %0d", $time,
							want.status, res_mon.status);
						fail_count++;
					end
					if (want.alloc_start !== res_mon.alloc_start) begin
						$display("%0t: alloc_start expected %0d actual %0d", $time,
							want.alloc_start, res_mon.alloc_start);
						fail_count++;
					end
				end
			end
			if (req_mon.valid && req_mon.ready)
				result_queue.push_back(predict_request(req_mon.req_type,
					req_mon.first_page, req_mon.run_length));
		end
	end
endmodule

// ===== sim/bitmap_run_page_allocator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_run_page_allocator_tb: stimulus and verdict for the page allocator
// Drives directed corner requests and random allocate/free/format traffic
// over several page-count settings with random idling on both channels.
// ----------------------------------------------------------------------------
module bitmap_run_page_allocator_tb;
	import bra_pkg::*;

	// Request code outside the defined set; the block answers it with an OK result and leaves the map unchanged.
	localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   fail_count;
	int   pending_results;
	int   idle_pct = 23;
	bit   hold_off = 1'b0;

	bra_req_if req ();
	bra_res_if res ();
	bra_cfg_if cfg ();

	bitmap_run_page_allocator dut (.clk(clk), .arst_n(arst_n), .req(req), .res(res),
		.cfg(cfg));

	bra_tb_checker chk (.clk(clk), .arst_n(arst_n), .req_mon(req), .res_mon(res),
		.cfg_mon(cfg), .fail_count(fail_count), .pending_results(pending_results));

	always #5 clk = ~clk;

	// Drive every input to a known value before reset releases.
	initial begin
		req.valid = 1'b0;
		req.req_type = REQ_ALLOC;
		req.first_page = '0;
		req.run_length = '0;
		cfg.valid = 1'b0;
		cfg.index = CFG_TOTAL;
		cfg.data = '0;
		res.ready = 1'b0;
	end

	// Receiver: random stalls, or a full stop while hold_off is set.
	always @(posedge clk) begin
		if (!arst_n) res.ready <= 1'b0;
		else res.ready <= !hold_off && ($urandom_range(99) >= idle_pct);
	end

	// Send one request beat; idle first at random, then hold until taken.
	// Valid stays high after the beat; the next call or a wait drops it.
	task automatic send_request(logic [REQ_W-1:0] kind, int first, int len);
		while ($urandom_range(99) < idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.req_type <= kind;
		req.first_page <= START_W'(first);
		req.run_length <= LEN_W'(len);
		@(posedge clk);
		while (!req.ready) @(posedge clk);
	endtask

	// Drop valid and wait until every accepted request has its result.
	task automatic wait_empty;
		req.valid <= 1'b0;
		@(posedge clk);
		while (pending_results != 0) @(posedge clk);
	endtask

	// Wait for every expected beat, then settle before touching registers.
	task automatic drain;
		wait_empty();
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= CFG_W'(value);
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		cfg.valid <= 1'b0;
		@(posedge clk);
	endtask

	// Mostly small runs, a few large ones; some noise kinds and negatives.
	task automatic random_request(int npages);
		int roll;
		int first;
		int len;
		logic [REQ_W-1:0] kind;
		roll = $urandom_range(99);
		if (roll < 50) kind = REQ_ALLOC;
		else if (roll < 88) kind = REQ_FREE;
		else if (roll < 95) kind = REQ_FORMAT;
		else kind = REQ_UNUSED;
		roll = $urandom_range(99);
		if (roll < 70) len = $urandom_range(16);
		else if (roll < 85) len = $urandom_range(npages);
		else if (roll < 92) len = -int'($urandom_range(4096, 1));
		else len = int'($urandom);
		first = $urandom_range(npages > 4095 ? 4095 : npages);
		send_request(kind, first, len);
	endtask

	initial begin
		int settings[5] = '{4096, 64, 2, 300, 8191};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed corners at reset settings.
		send_request(REQ_FORMAT, 0, 0);
		send_request(REQ_ALLOC, 0, 0);
		send_request(REQ_ALLOC, 0, 1);
		send_request(REQ_ALLOC, 0, -1);
		send_request(REQ_ALLOC, 0, -4096);
		send_request(REQ_ALLOC, 0, 4096);
		send_request(REQ_ALLOC, 0, 4094);
		send_request(REQ_ALLOC, 0, 1);
		send_request(REQ_FREE, 4095, 1);
		send_request(REQ_FREE, 4095, 2);
		send_request(REQ_FREE, 0, -5);
		send_request(REQ_FREE, 4095, 0);
		send_request(REQ_FREE, 0, 4096);
		send_request(REQ_FREE, 'hAAA, 'h1555);
		send_request(REQ_ALLOC, 'h555, 8191);
		send_request(REQ_UNUSED, 'hFFF, 'h1FFF);
		send_request(REQ_ALLOC, 0, 100);
		drain();

		// Format with too many reserved pages, then a short page count.
		write_reg(CFG_RESERVED, 5000);
		send_request(REQ_FORMAT, 0, 0);
		drain();
		write_reg(CFG_TOTAL, 0);
		write_reg(CFG_RESERVED, 3);
		send_request(REQ_FORMAT, 0, 0);
		send_request(REQ_FORMAT, 0, 0);
		send_request(REQ_ALLOC, 0, 1);
		send_request(REQ_FREE, 2, 0);
		send_request(REQ_FREE, 3, 0);
		drain();

		// Random phases over several settings.
		foreach (settings[s]) begin
			write_reg(CFG_TOTAL, settings[s]);
			write_reg(CFG_RESERVED, $urandom_range(s == 2 ? 2 : 64));
			send_request(REQ_FORMAT, 0, 0);
			if (s == 1) idle_pct = 0;
			for (int i = 0; i < 125; i++) begin
				// Stop the receiver for a long stretch so the block backs up.
				if (s == 3 && i == 10) begin
					hold_off = 1'b1;
					fork
						begin
							repeat (400) @(posedge clk);
							hold_off = 1'b0;
						end
					join_none
				end
				// Let the pipeline empty completely before resuming.
				if (i == 60) wait_empty();
				random_request(settings[s] > 4096 ? 4096 : settings[s]);
			end
			idle_pct = 23;
			drain();
		end

		drain();
		repeat (50) @(posedge clk);
		if (fail_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	// Hard stop for a hung run.
	initial begin
		#20ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
